### rtl/core/aff_pkg.sv
// ----------------------------------------------------------------------------
// aff_pkg: shared types, constants and fixed-point helpers
// Q16.16 rounding and saturation, CORDIC arctangent table, payload structs.
// ----------------------------------------------------------------------------
package aff_pkg;

	localparam int FRAC_BITS        = 16;
	localparam int DEF_CORDIC_STEPS = 16;
	localparam int MAX_STEPS        = 24;
	localparam int ROOT_BITS        = 32;
	localparam int ROT_W            = 34;
	localparam int VEC_W            = 64;
	localparam int SAT_W            = 72;

	localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
	localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

	localparam logic signed [SAT_W-1:0] RND_Q  = SAT_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [SAT_W-1:0] RND_30 = SAT_W'(1) << 29;
	localparam logic signed [SAT_W-1:0] MAX32  = SAT_W'(32'h7FFFFFFF);
	localparam logic signed [SAT_W-1:0] MIN32  = -MAX32 - SAT_W'(1);

	localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef enum logic [1:0] {
		CFG_ANCHOR_X = 2'd0,
		CFG_ANCHOR_Y = 2'd1,
		CFG_WIDTH    = 2'd2,
		CFG_HEIGHT   = 2'd3
	} cfg_idx_t;

	// parent matrix (identity already applied) and local placement
	typedef struct packed {
		logic signed [31:0] pa;
		logic signed [31:0] pb;
		logic signed [31:0] pc;
		logic signed [31:0] pd;
		logic signed [31:0] ptx;
		logic signed [31:0] pty;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
	} obj_t;

	typedef struct packed {
		logic signed [31:0] wa;
		logic signed [31:0] wb;
		logic signed [31:0] wc;
		logic signed [31:0] wd;
		logic signed [31:0] wtx;
		logic signed [31:0] wty;
	} wmat_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		if (v > MAX32) begin
			return 32'sh7FFFFFFF;
		end
		if (v < MIN32) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// round to nearest, ties up, drop FRAC_BITS
	function automatic logic signed [SAT_W-1:0] rnd_q(input logic signed [63:0] p);
		logic signed [SAT_W-1:0] t;
		t = SAT_W'(p) + RND_Q;
		return t >>> FRAC_BITS;
	endfunction

	function automatic logic signed [SAT_W-1:0] rnd_30(input logic signed [65:0] p);
		logic signed [SAT_W-1:0] t;
		t = SAT_W'(p) + RND_30;
		return t >>> 30;
	endfunction

endpackage

### rtl/core/aff_sincos.sv
// ----------------------------------------------------------------------------
// aff_sincos: pipelined CORDIC rotation
// One step per stage, Q30 cosine and sine of a 16-bit binary angle.
// ----------------------------------------------------------------------------
module aff_sincos import aff_pkg::*; #(
	parameter int STEPS = DEF_CORDIC_STEPS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [15:0]             in_angle,
	input  obj_t                    in_obj,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [ROT_W-1:0] out_cos,
	output logic signed [ROT_W-1:0] out_sin,
	output obj_t                    out_obj
);

	logic                    v_s  [0:STEPS];
	logic                    go_s [0:STEPS];
	logic signed [ROT_W-1:0] x_s  [0:STEPS];
	logic signed [ROT_W-1:0] y_s  [0:STEPS];
	logic [31:0]             z_s  [0:STEPS];
	logic                    f_s  [0:STEPS];
	obj_t                    o_s  [0:STEPS];

	logic        f_in;
	logic [31:0] z_in;

	// second and third quadrant: turn by a half and negate at the end
	always_comb begin
		f_in = in_angle[15] ^ in_angle[14];
		z_in = {in_angle ^ {f_in, 15'b0}, 16'b0};
	end

	for (genvar k = 0; k <= STEPS; k++) begin : g_st
		logic signed [ROT_W-1:0] xp, yp, xn, yn;
		logic [31:0]             zp, zn;
		logic                    fp, vp, gn;
		obj_t                    op;

		if (k == 0) begin : g_src0
			assign xp = ROT_W'(CORDIC_GAIN);
			assign yp = '0;
			assign zp = z_in;
			assign fp = f_in;
			assign vp = in_valid;
			assign op = in_obj;
		end else begin : g_src
			assign xp = x_s[k-1];
			assign yp = y_s[k-1];
			assign zp = z_s[k-1];
			assign fp = f_s[k-1];
			assign vp = v_s[k-1];
			assign op = o_s[k-1];
		end

		if (k == STEPS) begin : g_last
			assign gn = out_ready;
			assign xn = fp ? -xp : xp;
			assign yn = fp ? -yp : yp;
			assign zn = zp;
		end else begin : g_step
			assign gn = go_s[k+1];
			always_comb begin
				if (!zp[31]) begin
					xn = xp - (yp >>> k);
					yn = yp + (xp >>> k);
					zn = zp - ATAN_TAB[k];
				end else begin
					xn = xp + (yp >>> k);
					yn = yp - (xp >>> k);
					zn = zp + ATAN_TAB[k];
				end
			end
		end

		assign go_s[k] = !v_s[k] || gn;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (go_s[k]) begin
				v_s[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (go_s[k]) begin
				x_s[k] <= xn;
				y_s[k] <= yn;
				z_s[k] <= zn;
				f_s[k] <= fp;
				o_s[k] <= op;
			end
		end
	end

	assign in_ready  = go_s[0];
	assign out_valid = v_s[STEPS];
	assign out_cos   = x_s[STEPS];
	assign out_sin   = y_s[STEPS];
	assign out_obj   = o_s[STEPS];

endmodule

### rtl/core/aff_metric.sv
// ----------------------------------------------------------------------------
// aff_metric: column norms and world angle
// Squares and sums, then a bit-per-stage square root running in lockstep
// with a CORDIC vectoring pipeline for atan2(-c, d).
// ----------------------------------------------------------------------------
module aff_metric import aff_pkg::*; #(
	parameter int STEPS = DEF_CORDIC_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  wmat_t       in_mat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] out_scale_x,
	output logic [30:0] out_scale_y,
	output logic [15:0] out_angle,
	output wmat_t       out_mat
);

	// stage 0: squares and quadrant pre-rotation
	logic                    v_s0, go_s0;
	logic signed [63:0]      sqa_s0, sqb_s0, sqc_s0, sqd_s0;
	logic signed [VEC_W-1:0] vx_s0, vy_s0;
	logic [31:0]             vz_s0;
	logic                    zf_s0;
	wmat_t                   mat_s0;

	// stage 1: sums of squares
	logic                    v_s1, go_s1;
	logic [63:0]             nx_s1, ny_s1;
	logic signed [VEC_W-1:0] vx_s1, vy_s1;
	logic [31:0]             vz_s1;
	logic                    zf_s1;
	wmat_t                   mat_s1;

	// root and vectoring steps
	logic                    v_st   [0:ROOT_BITS-1];
	logic                    go_st  [0:ROOT_BITS-1];
	logic [63:0]             rmx_st [0:ROOT_BITS-1];
	logic [63:0]             rmy_st [0:ROOT_BITS-1];
	logic [31:0]             rtx_st [0:ROOT_BITS-1];
	logic [31:0]             rty_st [0:ROOT_BITS-1];
	logic signed [VEC_W-1:0] vx_st  [0:ROOT_BITS-1];
	logic signed [VEC_W-1:0] vy_st  [0:ROOT_BITS-1];
	logic [31:0]             vz_st  [0:ROOT_BITS-1];
	logic                    zf_st  [0:ROOT_BITS-1];
	wmat_t                   mat_st [0:ROOT_BITS-1];

	// final stage
	logic        v_sf, go_sf;
	logic [30:0] scx_sf, scy_sf;
	logic [15:0] ang_sf;
	wmat_t       mat_sf;

	logic signed [VEC_W-1:0] xi, yi, xr, yr;
	logic [31:0]             zr;

	always_comb begin
		xi = VEC_W'(in_mat.wd) <<< 28;
		yi = -(VEC_W'(in_mat.wc) <<< 28);
		if (xi < 0) begin
			if (yi >= 0) begin
				xr = yi;
				yr = -xi;
				zr = 32'h40000000;
			end else begin
				xr = -yi;
				yr = xi;
				zr = 32'hC0000000;
			end
		end else begin
			xr = xi;
			yr = yi;
			zr = '0;
		end
	end

	assign go_sf = !v_sf || out_ready;
	assign go_s1 = !v_s1 || go_st[0];
	assign go_s0 = !v_s0 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_sf <= 1'b0;
		end else begin
			if (go_s0) begin
				v_s0 <= in_valid;
			end
			if (go_s1) begin
				v_s1 <= v_s0;
			end
			if (go_sf) begin
				v_sf <= v_st[ROOT_BITS-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s0) begin
			sqa_s0 <= in_mat.wa * in_mat.wa;
			sqb_s0 <= in_mat.wb * in_mat.wb;
			sqc_s0 <= in_mat.wc * in_mat.wc;
			sqd_s0 <= in_mat.wd * in_mat.wd;
			vx_s0  <= xr;
			vy_s0  <= yr;
			vz_s0  <= zr;
			zf_s0  <= (in_mat.wc == '0) && (in_mat.wd == '0);
			mat_s0 <= in_mat;
		end
		if (go_s1) begin
			nx_s1  <= unsigned'(sqa_s0) + unsigned'(sqb_s0);
			ny_s1  <= unsigned'(sqc_s0) + unsigned'(sqd_s0);
			vx_s1  <= vx_s0;
			vy_s1  <= vy_s0;
			vz_s1  <= vz_s0;
			zf_s1  <= zf_s0;
			mat_s1 <= mat_s0;
		end
	end

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_st
		localparam int B = ROOT_BITS - 1 - k;
		logic [63:0]             rmxp, rmyp, rmxn, rmyn;
		logic [31:0]             rtxp, rtyp, rtxn, rtyn, vzp, vzn;
		logic [65:0]             trx, try_v;
		logic signed [VEC_W-1:0] vxp, vyp, vxn, vyn;
		logic                    zfp, vp, gn;
		wmat_t                   matp;

		if (k == 0) begin : g_src0
			assign rmxp = nx_s1;
			assign rmyp = ny_s1;
			assign rtxp = '0;
			assign rtyp = '0;
			assign vxp  = vx_s1;
			assign vyp  = vy_s1;
			assign vzp  = vz_s1;
			assign zfp  = zf_s1;
			assign vp   = v_s1;
			assign matp = mat_s1;
		end else begin : g_src
			assign rmxp = rmx_st[k-1];
			assign rmyp = rmy_st[k-1];
			assign rtxp = rtx_st[k-1];
			assign rtyp = rty_st[k-1];
			assign vxp  = vx_st[k-1];
			assign vyp  = vy_st[k-1];
			assign vzp  = vz_st[k-1];
			assign zfp  = zf_st[k-1];
			assign vp   = v_st[k-1];
			assign matp = mat_st[k-1];
		end

		if (k == ROOT_BITS - 1) begin : g_gl
			assign gn = go_sf;
		end else begin : g_gn
			assign gn = go_st[k+1];
		end

		// try root bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		always_comb begin
			trx   = (66'(rtxp) << (B + 1)) + (66'(1) << (2 * B));
			try_v = (66'(rtyp) << (B + 1)) + (66'(1) << (2 * B));
			rmxn  = rmxp;
			rtxn  = rtxp;
			rmyn  = rmyp;
			rtyn  = rtyp;
			if (66'(rmxp) >= trx) begin
				rmxn = rmxp - trx[63:0];
				rtxn = rtxp | (32'd1 << B);
			end
			if (66'(rmyp) >= try_v) begin
				rmyn = rmyp - try_v[63:0];
				rtyn = rtyp | (32'd1 << B);
			end
		end

		if (k < STEPS) begin : g_vec
			always_comb begin
				if (vyp > 0) begin
					vxn = vxp + (vyp >>> k);
					vyn = vyp - (vxp >>> k);
					vzn = vzp + ATAN_TAB[k];
				end else begin
					vxn = vxp - (vyp >>> k);
					vyn = vyp + (vxp >>> k);
					vzn = vzp - ATAN_TAB[k];
				end
			end
		end else begin : g_hold
			assign vxn = vxp;
			assign vyn = vyp;
			assign vzn = vzp;
		end

		assign go_st[k] = !v_st[k] || gn;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[k] <= 1'b0;
			end else if (go_st[k]) begin
				v_st[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (go_st[k]) begin
				rmx_st[k] <= rmxn;
				rmy_st[k] <= rmyn;
				rtx_st[k] <= rtxn;
				rty_st[k] <= rtyn;
				vx_st[k]  <= vxn;
				vy_st[k]  <= vyn;
				vz_st[k]  <= vzn;
				zf_st[k]  <= zfp;
				mat_st[k] <= matp;
			end
		end
	end

	logic [31:0] rtx_l, rty_l, zrnd;

	always_comb begin
		rtx_l = rtx_st[ROOT_BITS-1];
		rty_l = rty_st[ROOT_BITS-1];
		zrnd  = vz_st[ROOT_BITS-1] + 32'h00008000;
	end

	always_ff @(posedge clk) begin
		if (go_sf) begin
			scx_sf <= rtx_l[31] ? 31'h7FFFFFFF : rtx_l[30:0];
			scy_sf <= rty_l[31] ? 31'h7FFFFFFF : rty_l[30:0];
			ang_sf <= zf_st[ROOT_BITS-1] ? 16'd0 : zrnd[31:16];
			mat_sf <= mat_st[ROOT_BITS-1];
		end
	end

	assign in_ready    = go_s0;
	assign out_valid   = v_sf;
	assign out_scale_x = scx_sf;
	assign out_scale_y = scy_sf;
	assign out_angle   = ang_sf;
	assign out_mat     = mat_sf;

endmodule

### rtl/core/affine_2d_world_transform.sv
// ----------------------------------------------------------------------------
// affine_2d_world_transform: 2D scene graph world transform
// Local matrix from position, scale and rotation, composed with the parent.
// ----------------------------------------------------------------------------
// One object request enters per clock and one result leaves per clock while
// m_axis_tready is high; the whole datapath is a stall-able pipeline in which
// every stage holds its own valid bit, so bubbles close up when the output
// side stalls. From input request to result lie CORDIC_STEPS + 1 stages of
// sine/cosine rotation, six stages of matrix build and composition,
// 35 stages for the column norms (squares, sum, one root bit per stage, with
// the atan2 vectoring running alongside) and four stages for the bounds
// origin. All values are signed Q16.16, results saturate at the 32-bit
// limits, angles are 16-bit binary angles. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and take effect for requests
// accepted afterwards; write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module affine_2d_world_transform import aff_pkg::*; #(
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// parent_a, parent_b, parent_c, parent_d, parent_tx, parent_ty,
	// local_x, local_y, local_scale_x, local_scale_y, local_angle
	input  logic [335:0] s_axis_tdata,
	// has_parent
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// world_a, world_b, world_c, world_d, world_tx, world_ty, world_scale_x,
	// world_scale_y, world_angle, bounds_x, bounds_y, zero pad
	output logic [335:0] m_axis_tdata
);

	// configuration
	logic signed [31:0] anchor_x_q, anchor_y_q;
	logic [15:0]        width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q <= 32'sd32768;
			anchor_y_q <= 32'sd32768;
			width_q    <= 16'd100;
			height_q   <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ANCHOR_X: anchor_x_q <= cfg_data;
				CFG_ANCHOR_Y: anchor_y_q <= cfg_data;
				CFG_WIDTH:    width_q    <= cfg_data[15:0];
				CFG_HEIGHT:   height_q   <= cfg_data[15:0];
			endcase
		end
	end

	// unpack the request; no parent selects the identity
	obj_t obj_in;

	always_comb begin
		obj_in.pa  = s_axis_tuser ? s_axis_tdata[31:0]    : Q_ONE;
		obj_in.pb  = s_axis_tuser ? s_axis_tdata[63:32]   : '0;
		obj_in.pc  = s_axis_tuser ? s_axis_tdata[95:64]   : '0;
		obj_in.pd  = s_axis_tuser ? s_axis_tdata[127:96]  : Q_ONE;
		obj_in.ptx = s_axis_tuser ? s_axis_tdata[159:128] : '0;
		obj_in.pty = s_axis_tuser ? s_axis_tdata[191:160] : '0;
		obj_in.px  = s_axis_tdata[223:192];
		obj_in.py  = s_axis_tdata[255:224];
		obj_in.sx  = s_axis_tdata[287:256];
		obj_in.sy  = s_axis_tdata[319:288];
	end

	// sine and cosine of the local rotation
	logic                    sc_valid;
	logic signed [ROT_W-1:0] sc_cos, sc_sin;
	obj_t                    sc_obj;

	logic go_s1, go_s2, go_s3, go_s4, go_s5, go_s6;
	logic go_s7, go_s8, go_s9, go_s10;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_s7, v_s8, v_s9, v_s10;
	logic met_ready, met_valid;

	aff_sincos #(
		.STEPS(CORDIC_STEPS)
	) u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_angle  (s_axis_tdata[335:320]),
		.in_obj    (obj_in),
		.out_valid (sc_valid),
		.out_ready (go_s1),
		.out_cos   (sc_cos),
		.out_sin   (sc_sin),
		.out_obj   (sc_obj)
	);

	// advance a stage when it is empty or the next one advances
	assign go_s10 = !v_s10 || m_axis_tready;
	assign go_s9  = !v_s9  || go_s10;
	assign go_s8  = !v_s8  || go_s9;
	assign go_s7  = !v_s7  || go_s8;
	assign go_s6  = !v_s6  || met_ready;
	assign go_s5  = !v_s5  || go_s6;
	assign go_s4  = !v_s4  || go_s5;
	assign go_s3  = !v_s3  || go_s4;
	assign go_s2  = !v_s2  || go_s3;
	assign go_s1  = !v_s1  || go_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (go_s1)  v_s1  <= sc_valid;
			if (go_s2)  v_s2  <= v_s1;
			if (go_s3)  v_s3  <= v_s2;
			if (go_s4)  v_s4  <= v_s3;
			if (go_s5)  v_s5  <= v_s4;
			if (go_s6)  v_s6  <= v_s5;
			if (go_s7)  v_s7  <= met_valid;
			if (go_s8)  v_s8  <= v_s7;
			if (go_s9)  v_s9  <= v_s8;
			if (go_s10) v_s10 <= v_s9;
		end
	end

	// stage 1: local matrix products, Q30 by Q16.16
	logic signed [65:0] pa_s1, pb_s1, pc_s1, pd_s1;
	obj_t               obj_s1;

	always_ff @(posedge clk) begin
		if (go_s1) begin
			pa_s1  <= sc_cos * sc_obj.sx;
			pb_s1  <= sc_sin * sc_obj.sx;
			pc_s1  <= (-sc_sin) * sc_obj.sy;
			pd_s1  <= sc_cos * sc_obj.sy;
			obj_s1 <= sc_obj;
		end
	end

	// stage 2: round and saturate the local matrix
	logic signed [31:0] a_s2, b_s2, c_s2, d_s2;
	obj_t               obj_s2;

	always_ff @(posedge clk) begin
		if (go_s2) begin
			a_s2   <= sat32(rnd_30(pa_s1));
			b_s2   <= sat32(rnd_30(pb_s1));
			c_s2   <= sat32(rnd_30(pc_s1));
			d_s2   <= sat32(rnd_30(pd_s1));
			obj_s2 <= obj_s1;
		end
	end

	// stage 3: anchor offset products
	logic signed [63:0] q1_s3, q2_s3, q3_s3, q4_s3;
	logic signed [31:0] a_s3, b_s3, c_s3, d_s3;
	obj_t               obj_s3;

	always_ff @(posedge clk) begin
		if (go_s3) begin
			q1_s3  <= anchor_x_q * a_s2;
			q2_s3  <= anchor_y_q * c_s2;
			q3_s3  <= anchor_x_q * b_s2;
			q4_s3  <= anchor_y_q * d_s2;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			c_s3   <= c_s2;
			d_s3   <= d_s2;
			obj_s3 <= obj_s2;
		end
	end

	// stage 4: pull the translation back by the anchor
	logic signed [31:0] a_s4, b_s4, c_s4, d_s4, tx_s4, ty_s4;
	obj_t               obj_s4;

	always_ff @(posedge clk) begin
		if (go_s4) begin
			tx_s4  <= sat32(SAT_W'(obj_s3.px) - (rnd_q(q1_s3) + rnd_q(q2_s3)));
			ty_s4  <= sat32(SAT_W'(obj_s3.py) - (rnd_q(q3_s3) + rnd_q(q4_s3)));
			a_s4   <= a_s3;
			b_s4   <= b_s3;
			c_s4   <= c_s3;
			d_s4   <= d_s3;
			obj_s4 <= obj_s3;
		end
	end

	// stage 5: compose with the parent, twelve products
	logic signed [63:0] m_aa_s5, m_bc_s5, m_ab_s5, m_bd_s5;
	logic signed [63:0] m_ca_s5, m_dc_s5, m_cb_s5, m_dd_s5;
	logic signed [63:0] m_xa_s5, m_yc_s5, m_xb_s5, m_yd_s5;
	logic signed [31:0] ptx_s5, pty_s5;

	always_ff @(posedge clk) begin
		if (go_s5) begin
			m_aa_s5 <= a_s4 * obj_s4.pa;
			m_bc_s5 <= b_s4 * obj_s4.pc;
			m_ab_s5 <= a_s4 * obj_s4.pb;
			m_bd_s5 <= b_s4 * obj_s4.pd;
			m_ca_s5 <= c_s4 * obj_s4.pa;
			m_dc_s5 <= d_s4 * obj_s4.pc;
			m_cb_s5 <= c_s4 * obj_s4.pb;
			m_dd_s5 <= d_s4 * obj_s4.pd;
			m_xa_s5 <= tx_s4 * obj_s4.pa;
			m_yc_s5 <= ty_s4 * obj_s4.pc;
			m_xb_s5 <= tx_s4 * obj_s4.pb;
			m_yd_s5 <= ty_s4 * obj_s4.pd;
			ptx_s5  <= obj_s4.ptx;
			pty_s5  <= obj_s4.pty;
		end
	end

	// stage 6: world matrix sums
	wmat_t mat_s6;

	always_ff @(posedge clk) begin
		if (go_s6) begin
			mat_s6.wa  <= sat32(rnd_q(m_aa_s5) + rnd_q(m_bc_s5));
			mat_s6.wb  <= sat32(rnd_q(m_ab_s5) + rnd_q(m_bd_s5));
			mat_s6.wc  <= sat32(rnd_q(m_ca_s5) + rnd_q(m_dc_s5));
			mat_s6.wd  <= sat32(rnd_q(m_cb_s5) + rnd_q(m_dd_s5));
			mat_s6.wtx <= sat32(rnd_q(m_xa_s5) + rnd_q(m_yc_s5) + SAT_W'(ptx_s5));
			mat_s6.wty <= sat32(rnd_q(m_xb_s5) + rnd_q(m_yd_s5) + SAT_W'(pty_s5));
		end
	end

	// column norms and world angle
	logic [30:0] met_scx, met_scy;
	logic [15:0] met_ang;
	wmat_t       met_mat;

	aff_metric #(
		.STEPS(CORDIC_STEPS)
	) u_metric (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s6),
		.in_ready    (met_ready),
		.in_mat      (mat_s6),
		.out_valid   (met_valid),
		.out_ready   (go_s7),
		.out_scale_x (met_scx),
		.out_scale_y (met_scy),
		.out_angle   (met_ang),
		.out_mat     (met_mat)
	);

	// stage 7: world size products
	logic [46:0] pw_s7, ph_s7;
	logic [30:0] scx_s7, scy_s7;
	logic [15:0] ang_s7;
	wmat_t       mat_s7;

	always_ff @(posedge clk) begin
		if (go_s7) begin
			pw_s7  <= 47'(width_q) * 47'(met_scx);
			ph_s7  <= 47'(height_q) * 47'(met_scy);
			scx_s7 <= met_scx;
			scy_s7 <= met_scy;
			ang_s7 <= met_ang;
			mat_s7 <= met_mat;
		end
	end

	// stage 8: saturate world size
	logic signed [31:0] ww_s8, wh_s8;
	logic [30:0]        scx_s8, scy_s8;
	logic [15:0]        ang_s8;
	wmat_t              mat_s8;

	always_ff @(posedge clk) begin
		if (go_s8) begin
			ww_s8  <= (pw_s7 > 47'h7FFFFFFF) ? 32'sh7FFFFFFF : pw_s7[31:0];
			wh_s8  <= (ph_s7 > 47'h7FFFFFFF) ? 32'sh7FFFFFFF : ph_s7[31:0];
			scx_s8 <= scx_s7;
			scy_s8 <= scy_s7;
			ang_s8 <= ang_s7;
			mat_s8 <= mat_s7;
		end
	end

	// stage 9: anchor share of world size
	logic signed [63:0] bmx_s9, bmy_s9;
	logic [30:0]        scx_s9, scy_s9;
	logic [15:0]        ang_s9;
	wmat_t              mat_s9;

	always_ff @(posedge clk) begin
		if (go_s9) begin
			bmx_s9 <= ww_s8 * anchor_x_q;
			bmy_s9 <= wh_s8 * anchor_y_q;
			scx_s9 <= scx_s8;
			scy_s9 <= scy_s8;
			ang_s9 <= ang_s8;
			mat_s9 <= mat_s8;
		end
	end

	// stage 10: bounds origin, output register
	logic signed [31:0] bx_s10, by_s10;
	logic [30:0]        scx_s10, scy_s10;
	logic [15:0]        ang_s10;
	wmat_t              mat_s10;

	always_ff @(posedge clk) begin
		if (go_s10) begin
			bx_s10  <= sat32(SAT_W'(mat_s9.wtx) - rnd_q(bmx_s9));
			by_s10  <= sat32(SAT_W'(mat_s9.wty) - rnd_q(bmy_s9));
			scx_s10 <= scx_s9;
			scy_s10 <= scy_s9;
			ang_s10 <= ang_s9;
			mat_s10 <= mat_s9;
		end
	end

	assign m_axis_tvalid = v_s10;
	assign m_axis_tdata  = {2'b00, by_s10, bx_s10, ang_s10, scy_s10, scx_s10,
		mat_s10.wty, mat_s10.wtx, mat_s10.wd, mat_s10.wc, mat_s10.wb, mat_s10.wa};

`ifndef NO_ASSERTIONS
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output register is empty");

	a_zero_vector_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && mat_s10.wc == '0 && mat_s10.wd == '0) |-> ang_s10 == '0)
		else $error("nonzero angle for zero column");

	a_zero_column_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && mat_s10.wa == '0 && mat_s10.wb == '0) |-> scx_s10 == '0)
		else $error("nonzero scale for zero column");
`endif

endmodule
